FILE: rtl/afrg_pkg.sv
package afrg_pkg;

    localparam int unsigned WINDOW_TICKS = 60;

    localparam int unsigned FPS_W  = 8;
    localparam int unsigned IVL_W  = 6;
    localparam int unsigned PEND_W = 16;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned NS_W   = 32;
    localparam int unsigned SUM_W  = 40;
    localparam int unsigned ALU_W  = 48;
    localparam int unsigned REM_W  = 10;
    localparam int unsigned STEP_W = 5;

    localparam logic [CNT_W-1:0]  WIN_CNT      = CNT_W'(WINDOW_TICKS);
    localparam logic [FPS_W-1:0]  MIN_FPS      = 8'd30;
    localparam logic [IVL_W-1:0]  IVL_RESET    = 6'd33;
    localparam logic [REM_W-1:0]  IVL_DIVIDEND = 10'd1000;
    localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [PEND_W-1:0] PEND_MAX     = {PEND_W{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_END   = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        SK_BADD,
        SK_WADD,
        SK_WSUB,
        SK_CMPLT,
        SK_CMPGT,
        SK_KEEP
    } step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        logic [2:0]        shift;
        logic signed [2:0] adj;
    } step_t;

    typedef struct packed {
        logic [ALU_W-1:0] x;
        logic [ALU_W-1:0] y;
        logic             sub;
    } alu_req_t;

    // busy*100, then walk the window multiple through 50, 60, 70, 98, 95, 90
    function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
        step_t s;
        unique case (idx)
            5'd0:    s = '{SK_BADD,  3'd6, 3'sd0};
            5'd1:    s = '{SK_BADD,  3'd5, 3'sd0};
            5'd2:    s = '{SK_BADD,  3'd2, 3'sd0};
            5'd3:    s = '{SK_WADD,  3'd5, 3'sd0};
            5'd4:    s = '{SK_WADD,  3'd4, 3'sd0};
            5'd5:    s = '{SK_WADD,  3'd1, 3'sd0};
            5'd6:    s = '{SK_CMPLT, 3'd0, 3'sd3};
            5'd7:    s = '{SK_WADD,  3'd3, 3'sd0};
            5'd8:    s = '{SK_WADD,  3'd1, 3'sd0};
            5'd9:    s = '{SK_CMPLT, 3'd0, 3'sd2};
            5'd10:   s = '{SK_WADD,  3'd3, 3'sd0};
            5'd11:   s = '{SK_WADD,  3'd1, 3'sd0};
            5'd12:   s = '{SK_CMPLT, 3'd0, 3'sd1};
            5'd13:   s = '{SK_WADD,  3'd5, 3'sd0};
            5'd14:   s = '{SK_WSUB,  3'd2, 3'sd0};
            5'd15:   s = '{SK_CMPGT, 3'd0, -3'sd3};
            5'd16:   s = '{SK_WSUB,  3'd1, 3'sd0};
            5'd17:   s = '{SK_WSUB,  3'd0, 3'sd0};
            5'd18:   s = '{SK_CMPGT, 3'd0, -3'sd2};
            5'd19:   s = '{SK_WSUB,  3'd2, 3'sd0};
            5'd20:   s = '{SK_WSUB,  3'd0, 3'sd0};
            5'd21:   s = '{SK_CMPGT, 3'd0, -3'sd1};
            default: s = '{SK_KEEP,  3'd0, 3'sd0};
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/afrg_if.sv
interface afrg_item_if;
    import afrg_pkg::*;

    logic                  valid;
    logic                  ready;
    op_t                   op;
    logic [NS_W-1:0]       tick_ns;
    logic [NS_W-1:0]       render_ns;

    modport source (output valid, op, tick_ns, render_ns, input ready);
    modport sink   (input valid, op, tick_ns, render_ns, output ready);
endinterface

interface afrg_result_if;
    import afrg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  frame_go;
    logic [FPS_W-1:0]      current_fps;
    logic [IVL_W-1:0]      interval_ms;
    logic [PEND_W-1:0]     ticks_taken;

    modport source (output valid, frame_go, current_fps, interval_ms, ticks_taken,
                    input ready);
    modport sink   (input valid, frame_go, current_fps, interval_ms, ticks_taken,
                    output ready);
endinterface

FILE: rtl/afrg_addsub.sv
module afrg_addsub (
    input  afrg_pkg::alu_req_t          req,
    output logic [afrg_pkg::ALU_W:0]    res
);
    import afrg_pkg::*;

    logic [ALU_W:0] opb;

    assign opb = {1'b0, (req.sub ? ~req.y : req.y)};
    assign res = {1'b0, req.x} + opb + {{ALU_W{1'b0}}, req.sub};

endmodule

FILE: rtl/adaptive_frame_rate_governor.sv
// Adaptive frame-rate governor.
// item channel: one beat per event (op 0 timer tick, 1 frame begin, 2 frame end,
// 3 ignored). result channel: one beat per item beat, carrying frame_go,
// the rate in force, the sleep interval and the ticks consumed by a frame begin.
// cfg_we/cfg_data write target_fps; the rate in force reloads to it and the
// interval is recomputed, which keeps the block busy and drops any unfinished item.
// Every item runs one at a time through a small sequencer that drives a single
// shared 48-bit add/subtract unit. item.ready is high only in the idle state.
// Most items go from idle through execute to the result state. A tick that closes
// a window first runs stepped compares (100*busy against 50/60/70/98/95/90 times
// window time); a frame begin that changes the rate first runs repeated
// subtraction for 1000/fps.
// A result beat holds in its register until taken; the block accepts no new item
// while it waits, so a stalled receiver stalls the sender.
// Reset (rst_n, asynchronous, active low) sets the rate to 30 fps, the interval
// to 33 ms and clears all pending counts and sums.
module adaptive_frame_rate_governor (
    input  logic                        clk,
    input  logic                        rst_n,
    afrg_item_if.sink                   item,
    afrg_result_if.source               result,
    input  logic                        cfg_we,
    input  logic [afrg_pkg::FPS_W-1:0]  cfg_data
);
    import afrg_pkg::*;

    state_t             state_reg,         state_next;
    logic [FPS_W-1:0]   target_reg,        target_next;
    logic [FPS_W-1:0]   rate_now_reg,      rate_now_next;
    logic [FPS_W-1:0]   rate_next_reg,     rate_next_next;
    logic [IVL_W-1:0]   interval_reg,      interval_next;
    logic [PEND_W-1:0]  pend_reg,          pend_next;
    logic [CNT_W-1:0]   win_cnt_reg,       win_cnt_next;
    logic [SUM_W-1:0]   win_time_reg,      win_time_next;
    logic [SUM_W-1:0]   busy_reg,          busy_next;
    op_t                op_reg,            op_next;
    logic [NS_W-1:0]    arg_reg,           arg_next;
    logic [STEP_W-1:0]  step_reg,          step_next;
    logic [ALU_W-1:0]   b100_reg,          b100_next;
    logic [ALU_W-1:0]   pw_reg,            pw_next;
    logic [REM_W-1:0]   rem_reg,           rem_next;
    logic               div_out_reg,       div_out_next;
    logic               go_reg,            go_next;
    logic [PEND_W-1:0]  taken_reg,         taken_next;

    alu_req_t           alu_req;
    logic [ALU_W:0]     alu_res;
    step_t              step;
    logic [CNT_W-1:0]   cnt_inc;
    logic [SUM_W-1:0]   sum_sat;
    logic [9:0]         nt_full;
    logic [FPS_W-1:0]   nt_sel;
    logic [FPS_W-1:0]   cfg_fps;

    afrg_addsub u_addsub (
        .req (alu_req),
        .res (alu_res)
    );

    assign item.ready         = (state_reg == ST_IDLE) && !cfg_we;
    assign result.valid       = (state_reg == ST_OUT);
    assign result.frame_go    = go_reg;
    assign result.current_fps = rate_now_reg;
    assign result.interval_ms = interval_reg;
    assign result.ticks_taken = taken_reg;

    assign step    = step_rom(step_reg);
    assign cnt_inc = win_cnt_reg + 8'd1;
    assign sum_sat = alu_res[SUM_W] ? SUM_MAX : alu_res[SUM_W-1:0];
    assign cfg_fps = (cfg_data < MIN_FPS) ? MIN_FPS : cfg_data;
    assign nt_full = {2'b00, rate_now_reg} + {{7{step.adj[2]}}, step.adj};

    always_comb
    begin
        if ($signed(nt_full) > $signed({2'b00, target_reg}))
        begin
            nt_sel = target_reg;
        end
        else if ($signed(nt_full) < $signed({2'b00, MIN_FPS}))
        begin
            nt_sel = MIN_FPS;
        end
        else
        begin
            nt_sel = nt_full[FPS_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        rate_now_next  = rate_now_reg;
        rate_next_next = rate_next_reg;
        interval_next  = interval_reg;
        pend_next      = pend_reg;
        win_cnt_next   = win_cnt_reg;
        win_time_next  = win_time_reg;
        busy_next      = busy_reg;
        op_next        = op_reg;
        arg_next       = arg_reg;
        step_next      = step_reg;
        b100_next      = b100_reg;
        pw_next        = pw_reg;
        rem_next       = rem_reg;
        div_out_next   = div_out_reg;
        go_next        = go_reg;
        taken_next     = taken_reg;
        alu_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid && item.ready)
                begin
                    op_next    = item.op;
                    arg_next   = (item.op == OP_END) ? item.render_ns : item.tick_ns;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                go_next    = 1'b0;
                taken_next = '0;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        alu_req.x = {{(ALU_W-SUM_W){1'b0}}, win_time_reg};
                        alu_req.y = {{(ALU_W-NS_W){1'b0}}, arg_reg};
                        if (pend_reg != PEND_MAX)
                        begin
                            pend_next = pend_reg + 16'd1;
                        end
                        if (cnt_inc >= WIN_CNT)
                        begin
                            if (sum_sat != '0)
                            begin
                                win_time_next = sum_sat;
                                step_next     = '0;
                                b100_next     = '0;
                                pw_next       = '0;
                                state_next    = ST_EVAL;
                            end
                            else
                            begin
                                win_cnt_next  = '0;
                                win_time_next = '0;
                                state_next    = ST_OUT;
                            end
                        end
                        else
                        begin
                            win_cnt_next  = cnt_inc;
                            win_time_next = sum_sat;
                            state_next    = ST_OUT;
                        end
                    end
                    OP_BEGIN:
                    begin
                        taken_next = pend_reg;
                        pend_next  = '0;
                        go_next    = (pend_reg != '0);
                        if ((pend_reg != '0) && (rate_now_reg != rate_next_reg))
                        begin
                            rate_now_next = rate_next_reg;
                            rem_next      = IVL_DIVIDEND;
                            interval_next = '0;
                            div_out_next  = 1'b1;
                            state_next    = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    OP_END:
                    begin
                        alu_req.x  = {{(ALU_W-SUM_W){1'b0}}, busy_reg};
                        alu_req.y  = {{(ALU_W-NS_W){1'b0}}, arg_reg};
                        busy_next  = sum_sat;
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end

            ST_EVAL:
            begin
                unique case (step.kind)
                    SK_BADD:
                    begin
                        alu_req.x = b100_reg;
                        alu_req.y = {{(ALU_W-SUM_W){1'b0}}, busy_reg} << step.shift;
                        b100_next = alu_res[ALU_W-1:0];
                        step_next = step_reg + 5'd1;
                    end
                    SK_WADD, SK_WSUB:
                    begin
                        alu_req.x   = pw_reg;
                        alu_req.y   = {{(ALU_W-SUM_W){1'b0}}, win_time_reg} << step.shift;
                        alu_req.sub = (step.kind == SK_WSUB);
                        pw_next     = alu_res[ALU_W-1:0];
                        step_next   = step_reg + 5'd1;
                    end
                    SK_CMPLT, SK_CMPGT:
                    begin
                        alu_req.x   = (step.kind == SK_CMPLT) ? b100_reg : pw_reg;
                        alu_req.y   = (step.kind == SK_CMPLT) ? pw_reg : b100_reg;
                        alu_req.sub = 1'b1;
                        if (!alu_res[ALU_W])
                        begin
                            rate_next_next = nt_sel;
                            busy_next      = '0;
                            win_cnt_next   = '0;
                            win_time_next  = '0;
                            state_next     = ST_OUT;
                        end
                        else
                        begin
                            step_next = step_reg + 5'd1;
                        end
                    end
                    default:
                    begin
                        rate_next_next = nt_sel;
                        busy_next      = '0;
                        win_cnt_next   = '0;
                        win_time_next  = '0;
                        state_next     = ST_OUT;
                    end
                endcase
            end

            ST_DIV:
            begin
                alu_req.x   = {{(ALU_W-REM_W){1'b0}}, rem_reg};
                alu_req.y   = {{(ALU_W-FPS_W){1'b0}}, rate_now_reg};
                alu_req.sub = 1'b1;
                if (alu_res[ALU_W])
                begin
                    rem_next      = alu_res[REM_W-1:0];
                    interval_next = interval_reg + 6'd1;
                end
                else
                begin
                    state_next = div_out_reg ? ST_OUT : ST_IDLE;
                end
            end

            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            target_next   = cfg_fps;
            rate_now_next = cfg_fps;
            rem_next      = IVL_DIVIDEND;
            interval_next = '0;
            div_out_next  = 1'b0;
            state_next    = ST_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= MIN_FPS;
            rate_now_reg  <= MIN_FPS;
            rate_next_reg <= MIN_FPS;
            interval_reg  <= IVL_RESET;
            pend_reg      <= '0;
            win_cnt_reg   <= '0;
            win_time_reg  <= '0;
            busy_reg      <= '0;
            op_reg        <= OP_NOP;
            arg_reg       <= '0;
            step_reg      <= '0;
            b100_reg      <= '0;
            pw_reg        <= '0;
            rem_reg       <= '0;
            div_out_reg   <= 1'b0;
            go_reg        <= 1'b0;
            taken_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            rate_now_reg  <= rate_now_next;
            rate_next_reg <= rate_next_next;
            interval_reg  <= interval_next;
            pend_reg      <= pend_next;
            win_cnt_reg   <= win_cnt_next;
            win_time_reg  <= win_time_next;
            busy_reg      <= busy_next;
            op_reg        <= op_next;
            arg_reg       <= arg_next;
            step_reg      <= step_next;
            b100_reg      <= b100_next;
            pw_reg        <= pw_next;
            rem_reg       <= rem_next;
            div_out_reg   <= div_out_next;
            go_reg        <= go_next;
            taken_reg     <= taken_next;
        end
    end

endmodule
